>>> sv/osrw_pkg.sv
package osrw_pkg;

  // Table and queue geometry
  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int QUEUE_DEPTH = 256;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_BITS   = 48;

  // Request field widths
  localparam int ACTION_W = 3;
  localparam int SLOT_W   = 4;
  localparam int OWNER_W  = 8;
  localparam int RNUM_W   = 16;
  localparam int LEN_W    = 31;
  localparam int KIND_W   = 2;
  localparam int SPAN_W   = 33;
  localparam int SHIFT_W  = 5;

  // Page shift limits and reset value
  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

  // Queue entry: fault address, page base, then tag {owner, range number, kind}
  localparam int TAG_W   = OWNER_W + RNUM_W + KIND_W;
  localparam int QWORD_W = 2 * ADDR_BITS + TAG_W;

  // Stream payload widths
  localparam int IN_BITS  = ACTION_W + SLOT_W + OWNER_W + RNUM_W + ADDR_BITS + LEN_W + KIND_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 + OWNER_W + 2 * ADDR_BITS + RNUM_W + KIND_W + QCNT_W + 1;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_PAGE_SHIFT = 3'd0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ARM    = 3'd0,
    ACT_ACCESS = 3'd1,
    ACT_DRAIN  = 3'd2,
    ACT_DISARM = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

>>> sv/one_shot_range_watch_unit.sv
// One-shot range watch unit. Sixteen slots each watch a page-rounded address
// range; an access request fires the lowest valid, unfired slot that holds its
// address and queues one event (fault address, page base, owner, range number,
// kind) into a 256-entry event queue kept in a single-port-read RAM. Drain pops
// the oldest event, disarm drops one owner's slots, clear-all drops every slot.
// A full queue drops the event and sets a sticky overflow flag that only reset
// clears. Every request returns exactly one result carrying the queue count and
// the overflow flag after the request. Each request first reads the queue head
// from the event RAM as it is taken, then compares the slots and commits in the
// execute state; a new request is taken only after the previous one commits, and
// a request waits in the execute state while an earlier result is still held.
// Reset is synchronous; the event RAM needs no clearing pass.
module one_shot_range_watch_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // fields from bit 0: action, slot, owner_id, range_number, address, length,
  // access_kind
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [osrw_pkg::IN_W-1:0]              in_tdata,
  // fields from bit 0: handled, event_valid, event_owner, event_fault_address,
  // event_page_base, event_range_number, event_kind, pending_count, overflow
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [osrw_pkg::OUT_W-1:0]             out_tdata,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [osrw_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [osrw_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [osrw_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                   cfg_pready
);

  import osrw_pkg::*;

  state_t state_r, state_nxt;

  // Request registers
  logic [ACTION_W-1:0]  req_action_r;
  logic [SLOT_W-1:0]    req_slot_r;
  logic [OWNER_W-1:0]   req_owner_r;
  logic [RNUM_W-1:0]    req_rnum_r;
  logic [ADDR_BITS-1:0] req_addr_r;
  logic [LEN_W-1:0]     req_len_r;
  logic [KIND_W-1:0]    req_kind_r;

  // Slot table
  logic [NUM_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic [NUM_SLOTS-1:0] slot_fired_r, slot_fired_nxt;
  logic [ADDR_BITS-1:0] slot_base_r  [NUM_SLOTS];
  logic [SPAN_W-1:0]    slot_span_r  [NUM_SLOTS];
  logic [OWNER_W-1:0]   slot_owner_r [NUM_SLOTS];
  logic [RNUM_W-1:0]    slot_rnum_r  [NUM_SLOTS];

  // Queue control
  logic [QPTR_W-1:0] q_head_r, q_head_nxt;
  logic [QPTR_W-1:0] q_tail_r, q_tail_nxt;
  logic [QCNT_W-1:0] q_count_r, q_count_nxt;
  logic              overflow_r, overflow_nxt;

  logic [SHIFT_W-1:0] page_shift_r, page_shift_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r, out_data_nxt;

  logic               accept;
  logic               commit;
  logic               q_we;
  logic [QWORD_W-1:0] q_wdata;
  logic [QWORD_W-1:0] q_rdata;

  logic [SHIFT_W-1:0]   eff_shift;
  logic [ADDR_BITS-1:0] lo_mask;
  logic [ADDR_BITS-1:0] arm_base;
  logic [SPAN_W-1:0]    arm_span;
  logic [SPAN_W-1:0]    arm_sum;
  logic                 arm_we;

  logic [ADDR_BITS-1:0]  slot_diff [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]  hit;
  logic                  hit_any;
  logic [SLOT_IDX_W-1:0] hit_idx;
  logic                  q_full;
  logic                  q_empty;

  logic                  handled;
  logic                  ev_valid;
  logic [OWNER_W-1:0]    ev_owner;
  logic [ADDR_BITS-1:0]  ev_fault;
  logic [ADDR_BITS-1:0]  ev_base;
  logic [RNUM_W-1:0]     ev_rnum;
  logic [KIND_W-1:0]     ev_kind;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_PAGE_SHIFT) ?
                      CFG_DATA_W'(page_shift_r) : '0;

  always_comb begin
    page_shift_nxt = page_shift_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
        cfg_paddr == REG_PAGE_SHIFT) begin
      page_shift_nxt = cfg_pwdata[SHIFT_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_EXEC: commit    = !out_valid_r || out_tready;
      default: begin
        in_tready = 1'b0;
        commit    = 1'b0;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // Page rounding for arm
  always_comb begin
    if (page_shift_r < SHIFT_MIN) begin
      eff_shift = SHIFT_MIN;
    end else if (page_shift_r > SHIFT_MAX) begin
      eff_shift = SHIFT_MAX;
    end else begin
      eff_shift = page_shift_r;
    end
    lo_mask  = ~({ADDR_BITS{1'b1}} << eff_shift);
    arm_base = req_addr_r & ~lo_mask;
    arm_sum  = SPAN_W'(req_addr_r & lo_mask) + SPAN_W'(req_len_r) +
               lo_mask[SPAN_W-1:0];
    arm_span = arm_sum & ~lo_mask[SPAN_W-1:0];
  end

  // Parallel slot compare, lowest slot wins
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_diff[i] = req_addr_r - slot_base_r[i];
      hit[i] = slot_valid_r[i] && !slot_fired_r[i] &&
               req_addr_r >= slot_base_r[i] &&
               slot_diff[i] < ADDR_BITS'(slot_span_r[i]);
    end
    hit_any = |hit;
    hit_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) hit_idx = SLOT_IDX_W'(i);
    end
  end

  assign q_full  = (q_count_r >= QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (q_count_r == '0);
  assign q_wdata = {slot_owner_r[hit_idx], slot_rnum_r[hit_idx], req_kind_r,
                    slot_base_r[hit_idx], req_addr_r};

  // Request execution
  always_comb begin
    slot_valid_nxt = slot_valid_r;
    slot_fired_nxt = slot_fired_r;
    q_head_nxt     = q_head_r;
    q_tail_nxt     = q_tail_r;
    q_count_nxt    = q_count_r;
    overflow_nxt   = overflow_r;
    arm_we         = 1'b0;
    q_we           = 1'b0;
    handled        = 1'b0;
    ev_valid       = 1'b0;
    ev_owner       = '0;
    ev_fault       = '0;
    ev_base        = '0;
    ev_rnum        = '0;
    ev_kind        = '0;
    if (commit) begin
      unique case (req_action_r)
        ACT_ARM: begin
          if (int'(req_slot_r) < NUM_SLOTS) begin
            arm_we = 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (int'(req_slot_r) == i) begin
                slot_valid_nxt[i] = 1'b1;
                slot_fired_nxt[i] = 1'b0;
              end
            end
          end
        end
        ACT_ACCESS: begin
          if (hit_any) begin
            handled = 1'b1;
            slot_fired_nxt[hit_idx] = 1'b1;
            if (q_full) begin
              overflow_nxt = 1'b1;
            end else begin
              q_we        = 1'b1;
              q_tail_nxt  = (q_tail_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail_r + 1'b1;
              q_count_nxt = q_count_r + 1'b1;
            end
          end
        end
        ACT_DRAIN: begin
          if (!q_empty) begin
            ev_valid    = 1'b1;
            ev_fault    = q_rdata[ADDR_BITS-1:0];
            ev_base     = q_rdata[2*ADDR_BITS-1:ADDR_BITS];
            ev_kind     = q_rdata[2*ADDR_BITS +: KIND_W];
            ev_rnum     = q_rdata[2*ADDR_BITS+KIND_W +: RNUM_W];
            ev_owner    = q_rdata[2*ADDR_BITS+KIND_W+RNUM_W +: OWNER_W];
            q_head_nxt  = (q_head_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_r + 1'b1;
            q_count_nxt = q_count_r - 1'b1;
          end
        end
        ACT_DISARM: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_owner_r[i] == req_owner_r) slot_valid_nxt[i] = 1'b0;
          end
        end
        ACT_CLEAR: slot_valid_nxt = '0;
        default: ;
      endcase
    end
  end

  // Result register, freed as the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (commit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'({overflow_nxt, q_count_nxt, ev_kind, ev_rnum, ev_base,
                              ev_fault, ev_owner, ev_valid, handled});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      slot_fired_r <= '0;
      q_head_r     <= '0;
      q_tail_r     <= '0;
      q_count_r    <= '0;
      overflow_r   <= 1'b0;
      page_shift_r <= SHIFT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      slot_fired_r <= slot_fired_nxt;
      q_head_r     <= q_head_nxt;
      q_tail_r     <= q_tail_nxt;
      q_count_r    <= q_count_nxt;
      overflow_r   <= overflow_nxt;
      page_shift_r <= page_shift_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: request capture, slot fields, result data
  always_ff @(posedge clk) begin
    if (accept) begin
      {req_kind_r, req_len_r, req_addr_r, req_rnum_r, req_owner_r, req_slot_r,
       req_action_r} <= in_tdata[IN_BITS-1:0];
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (arm_we && int'(req_slot_r) == i) begin
        slot_base_r[i]  <= arm_base;
        slot_span_r[i]  <= arm_span;
        slot_owner_r[i] <= req_owner_r;
        slot_rnum_r[i]  <= req_rnum_r;
      end
    end
    out_data_r <= out_data_nxt;
  end

  // Event queue storage; head is read as each request is taken
  osrw_ram #(
    .WIDTH(QWORD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_tail_r),
    .wdata(q_wdata),
    .re   (accept),
    .raddr(q_head_r),
    .rdata(q_rdata)
  );

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("event count above queue depth");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |=> overflow_r)
    else $error("overflow flag dropped without reset");

  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> !commit && state_r == S_IDLE)
    else $error("request committed twice");

  a_queue_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_we |-> !q_full && handled)
    else $error("queue written while full or without a slot match");
`endif

endmodule

>>> sv/osrw_ram.sv
module osrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
